// ----- rtl/ikc_pkg.sv -----
// Shared constants and the arctangent table for the two-link inverse kinematics core.
package ikc_pkg;

	localparam int FIELD_W       = 19;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ANGLE_BITS    = 30;
	localparam int ATAN_STEPS    = 31;
	localparam int ZW            = 34;

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;

	// round(atan(2^-i) * 2^30)
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] t;
		unique case (i)
			0:  t = 34'sd843314857;
			1:  t = 34'sd497837829;
			2:  t = 34'sd263043837;
			3:  t = 34'sd133525159;
			4:  t = 34'sd67021687;
			5:  t = 34'sd33543516;
			6:  t = 34'sd16775851;
			7:  t = 34'sd8388437;
			8:  t = 34'sd4194283;
			9:  t = 34'sd2097149;
			default: t = ZW'(64'sd1 <<< (30 - i));
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/ikc_if.sv -----
// Valid/ready channel interfaces for targets and joint angle results.
interface ikc_target_if import ikc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] target_x;
	logic signed [FIELD_W-1:0] target_y;

	modport source (output valid, output target_x, output target_y, input ready);
	modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface ikc_result_if import ikc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] shoulder_angle;
	logic signed [FIELD_W-1:0] elbow_angle;
	logic                      unreachable;

	modport source (output valid, output shoulder_angle, output elbow_angle,
		output unreachable, input ready);
	modport sink   (input valid, input shoulder_angle, input elbow_angle,
		input unreachable, output ready);
endinterface

// ----- rtl/ikc_isqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage.
module ikc_isqrt import ikc_pkg::*; #(
	parameter int N = FRAC_BITS_DEF + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vin,
	input  logic [2*N-1:0] rad,
	output logic           vout,
	output logic [N-1:0]   root
);
	localparam int RW = 2 * N;

	logic [RW-1:0] rem_s [N];
	logic [RW-1:0] res_s [N];
	logic          v_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - k));
		logic [RW-1:0] rem_i, res_i, trial;
		logic          v_i;

		if (k == 0) begin : g_first
			assign rem_i = rad;
			assign res_i = '0;
			assign v_i   = vin;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign res_i = res_s[k-1];
			assign v_i   = v_s[k-1];
		end

		assign trial = res_i + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_s[k] <= rem_i - trial;
					res_s[k] <= (res_i >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_i;
					res_s[k] <= res_i >> 1;
				end
			end
		end
	end

	assign vout = v_s[N-1];
	assign root = res_s[N-1][N-1:0];
endmodule

// ----- rtl/ikc_cordic.sv -----
// Pipelined vectoring CORDIC atan2 with output rounding and clamp to +-pi.
module ikc_cordic import ikc_pkg::*; #(
	parameter int W         = 24,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vin,
	input  logic signed [W-1:0]       xin,
	input  logic signed [W-1:0]       yin,
	output logic                      vout,
	output logic signed [FIELD_W-1:0] angle
);
	localparam int SH = ANGLE_BITS - FRAC_BITS;
	localparam logic signed [ZW-1:0] RND = (SH == 0) ? '0 : ZW'(64'sd1 <<< (SH - 1));
	localparam logic signed [ZW-1:0] LIM = (PI_Q30 + RND) >>> SH;
	localparam logic signed [ZW-1:0] NLIM = -LIM;

	// stage 0 is the quarter-turn, stages 1..ATAN_STEPS the micro-rotations
	logic signed [W-1:0]  x_s [ATAN_STEPS+1];
	logic signed [W-1:0]  y_s [ATAN_STEPS+1];
	logic signed [ZW-1:0] z_s [ATAN_STEPS+1];
	logic                 zero_s [ATAN_STEPS+1];
	logic                 v_s [ATAN_STEPS+1];

	logic signed [FIELD_W-1:0] angle_q;
	logic                      v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (xin == '0) && (yin == '0);
			if (!xin[W-1]) begin
				x_s[0] <= xin;
				y_s[0] <= yin;
				z_s[0] <= '0;
			end else if (!yin[W-1]) begin
				x_s[0] <= yin;
				y_s[0] <= -xin;
				z_s[0] <= HALF_PI_Q30;
			end else begin
				x_s[0] <= -yin;
				y_s[0] <= xin;
				z_s[0] <= -HALF_PI_Q30;
			end
		end
	end

	for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] T = atan_q30(i);
		logic signed [W-1:0] dx, dy;
		logic                pos;

		assign dx  = x_s[i] >>> i;
		assign dy  = y_s[i] >>> i;
		assign pos = !y_s[i][W-1] && (y_s[i] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (pos) begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + T;
				end else begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - T;
				end
			end
		end
	end

	logic signed [ZW-1:0] zr;
	assign zr = (z_s[ATAN_STEPS] + RND) >>> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[ATAN_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (zero_s[ATAN_STEPS]) begin
				angle_q <= '0;
			end else if (zr > LIM) begin
				angle_q <= LIM[FIELD_W-1:0];
			end else if (zr < NLIM) begin
				angle_q <= NLIM[FIELD_W-1:0];
			end else begin
				angle_q <= zr[FIELD_W-1:0];
			end
		end
	end

	assign vout  = v_q;
	assign angle = angle_q;
endmodule

// ----- rtl/two_link_inverse_kinematics_core.sv -----
// Top level of the two-link planar arm inverse kinematics core.
// Takes a target (x, y) in Q.FRAC_BITS fixed point, link lengths 1.0, and returns the
// elbow-up shoulder and elbow angles in radians, Q.FRAC_BITS, rounded half up and
// clamped to [-pi, pi]. Targets beyond reach (x^2+y^2 > 4) or at the origin raise
// unreachable and return zero angles. The core is a single pipeline: one request is
// taken every cycle while the result is taken or the output stage is empty. The depth
// is set by the seven front stages, the square root (FRAC_BITS + 1 stages, one root
// bit each), two product stages and the two CORDIC units (33 stages: quarter turn,
// 31 micro-rotations, rounding), which run side by side. When the result is not
// taken the whole pipeline holds; no request is lost or repeated.
module two_link_inverse_kinematics_core import ikc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ikc_target_if.sink      target,
	ikc_result_if.source    result
);
	localparam int R2W = 2 * FIELD_W;          // x^2 + y^2
	localparam int HW  = FRAC_BITS + 2;        // h = 1 + c2, up to 2.0
	localparam int C2W = FRAC_BITS + 2;        // c2 in [-1, 1]
	localparam int AW  = FRAC_BITS + 1;        // |c2|
	localparam int N   = FRAC_BITS + 1;        // root bits
	localparam int RW  = 2 * N;                // radicand
	localparam int PW  = FRAC_BITS + 22;       // products
	localparam int SW  = FRAC_BITS + 23;       // shoulder CORDIC width
	localparam int EW  = FRAC_BITS + 4;        // elbow CORDIC width
	localparam int CL  = ATAN_STEPS + 2;       // stages per CORDIC unit

	localparam logic [63:0]           REACH = 64'd4 << (2 * FRAC_BITS);
	localparam logic signed [HW:0]    ONE_E = (HW + 1)'(1) << FRAC_BITS;
	localparam logic [RW-1:0]         ONE2  = RW'(1) << (2 * FRAC_BITS);

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic [HW-1:0]             h;
		logic signed [C2W-1:0]     c2;
		logic                      bad;
	} sb_t;

	// global advance: the output stage is free or being drained
	logic en;
	logic v_out;
	assign en           = !v_out || result.ready;
	assign target.ready = en;

	// s1: input capture
	logic signed [FIELD_W-1:0] x_s1, y_s1;
	// s2: squares (up to 2^36 for the most negative field value)
	logic signed [FIELD_W-1:0] x_s2, y_s2;
	logic [R2W-2:0]            xx_s2, yy_s2;
	// s3: radius squared
	logic signed [FIELD_W-1:0] x_s3, y_s3;
	logic [R2W-1:0]            r2_s3;
	// s4..s7: elbow cosine, |c2|, c2^2, radicand
	sb_t                       sb_s4, sb_s5, sb_s6, sb_s7;
	logic [AW-1:0]             a_s5;
	logic [RW-1:0]             sq_s6, rad_s7;
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= target.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	logic [HW-1:0]         h_nx;
	logic signed [HW:0]    c2_wide;
	assign h_nx    = HW'(r2_s3 >> (FRAC_BITS + 1));
	assign c2_wide = $signed({1'b0, h_nx}) - ONE_E;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= target.target_x;
			y_s1 <= target.target_y;

			x_s2  <= x_s1;
			y_s2  <= y_s1;
			xx_s2 <= (R2W - 1)'(x_s1 * x_s1);
			yy_s2 <= (R2W - 1)'(y_s1 * y_s1);

			x_s3  <= x_s2;
			y_s3  <= y_s2;
			r2_s3 <= R2W'(xx_s2) + R2W'(yy_s2);

			sb_s4.x   <= x_s3;
			sb_s4.y   <= y_s3;
			sb_s4.h   <= h_nx;
			sb_s4.c2  <= C2W'(c2_wide);
			sb_s4.bad <= (r2_s3 == '0) || (64'(r2_s3) > REACH);

			sb_s5 <= sb_s4;
			a_s5  <= sb_s4.c2[C2W-1] ? AW'(-sb_s4.c2) : AW'(sb_s4.c2);

			sb_s6 <= sb_s5;
			sq_s6 <= RW'(a_s5 * a_s5);

			sb_s7  <= sb_s6;
			rad_s7 <= ONE2 - sq_s6;
		end
	end

	// elbow sine: s2 = floor(sqrt(1 - c2^2))
	logic          v_rt;
	logic [N-1:0]  s2_rt;
	sb_t           sb_d [N];

	ikc_isqrt #(.N(N)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_s7),
		.rad    (rad_s7),
		.vout   (v_rt),
		.root   (s2_rt)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sb_d[0] <= sb_s7;
			for (int k = 1; k < N; k++) begin
				sb_d[k] <= sb_d[k-1];
			end
		end
	end

	// p1: products for the 2x2 solve; p2: its numerator and denominator
	logic signed [PW-1:0]  hy_p1, sx_p1, hx_p1, sy_p1;
	logic signed [C2W-1:0] c2_p1, c2_p2;
	logic [N-1:0]          s2_p1, s2_p2;
	logic                  bad_p1, bad_p2, v_p1, v_p2;
	logic signed [SW-1:0]  num_p2, den_p2;
	logic signed [HW:0]    hs;
	logic signed [N:0]     s2s;

	assign hs  = $signed({1'b0, sb_d[N-1].h});
	assign s2s = $signed({1'b0, s2_rt});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
		end else if (en) begin
			v_p1 <= v_rt;
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hy_p1  <= PW'(hs * sb_d[N-1].y);
			hx_p1  <= PW'(hs * sb_d[N-1].x);
			sx_p1  <= PW'(s2s * sb_d[N-1].x);
			sy_p1  <= PW'(s2s * sb_d[N-1].y);
			c2_p1  <= sb_d[N-1].c2;
			s2_p1  <= s2_rt;
			bad_p1 <= sb_d[N-1].bad;

			num_p2 <= SW'(hy_p1) - SW'(sx_p1);
			den_p2 <= SW'(hx_p1) + SW'(sy_p1);
			c2_p2  <= c2_p1;
			s2_p2  <= s2_p1;
			bad_p2 <= bad_p1;
		end
	end

	// two CORDIC units in lockstep: shoulder on (num, den), elbow on (s2, c2)
	logic signed [FIELD_W-1:0] sh_ang, el_ang;
	logic signed [EW-1:0]      el_x, el_y;
	logic                      bad_d [CL];

	assign el_x = EW'(c2_p2);
	assign el_y = $signed(EW'(s2_p2));

	ikc_cordic #(.W(SW), .FRAC_BITS(FRAC_BITS)) u_cordic_sh (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_p2),
		.xin    (den_p2),
		.yin    (num_p2),
		.vout   (v_out),
		.angle  (sh_ang)
	);

	ikc_cordic #(.W(EW), .FRAC_BITS(FRAC_BITS)) u_cordic_el (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_p2),
		.xin    (el_x),
		.yin    (el_y),
		.vout   (),
		.angle  (el_ang)
	);

	// unreachable flag (out of reach or origin) follows its request through the CORDIC stages
	always_ff @(posedge clk) begin
		if (en) begin
			bad_d[0] <= bad_p2;
			for (int k = 1; k < CL; k++) begin
				bad_d[k] <= bad_d[k-1];
			end
		end
	end

	assign result.valid          = v_out;
	assign result.unreachable    = bad_d[CL-1];
	assign result.shoulder_angle = bad_d[CL-1] ? '0 : sh_ang;
	assign result.elbow_angle    = bad_d[CL-1] ? '0 : el_ang;
endmodule
